[design/spiir_pkg.sv]
package spiir_pkg;

    localparam int TAPS        = 4;
    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 24;
    localparam int COEF_IDX_W  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_SHIFT  = 20;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 4;

    // register map: den_coef_1..4 first, then num_coef_1..4
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BASE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } spiir_state_t;

    typedef struct packed {
        logic load_sample;
        logic clear;
        logic mac;
        logic finish;
    } spiir_cmd_t;

    typedef struct packed {
        logic last_step;
        logic out_free;
    } spiir_sts_t;

endpackage

[design/spiir_ctrl.sv]
module spiir_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  spiir_pkg::spiir_sts_t sts,
    output spiir_pkg::spiir_cmd_t cmd
);

    spiir_pkg::spiir_state_t state_reg;
    spiir_pkg::spiir_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spiir_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spiir_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = spiir_pkg::ST_MAC;
            end
            spiir_pkg::ST_MAC: begin
                if (sts.last_step) state_next = spiir_pkg::ST_DRAIN;
            end
            spiir_pkg::ST_DRAIN: begin
                state_next = spiir_pkg::ST_ROUND;
            end
            spiir_pkg::ST_ROUND: begin
                if (sts.out_free) state_next = spiir_pkg::ST_IDLE;
            end
            default: state_next = spiir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            spiir_pkg::ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.load_sample = s_tvalid;
                cmd.clear       = s_tvalid;
            end
            spiir_pkg::ST_MAC: begin
                cmd.mac = 1'b1;
            end
            spiir_pkg::ST_DRAIN: begin
            end
            spiir_pkg::ST_ROUND: begin
                cmd.finish = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[design/spiir_dp.sv]
module spiir_dp #(
    parameter int ORDER = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [spiir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spiir_pkg::COEF_W-1:0]         cfg_data,
    input  logic [spiir_pkg::SAMPLE_W-1:0]       s_tdata,
    input  logic                                 m_tready,
    input  spiir_pkg::spiir_cmd_t                cmd,
    output spiir_pkg::spiir_sts_t                sts,
    output logic                                 m_tvalid,
    output logic [spiir_pkg::SAMPLE_W-1:0]       m_tdata
);

    localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);
    localparam int SW    = spiir_pkg::SAMPLE_W;
    localparam int CW    = spiir_pkg::COEF_W;
    localparam int PW    = spiir_pkg::PROD_W;
    localparam int AW    = spiir_pkg::ACC_W;
    localparam int FS    = spiir_pkg::FRAC_SHIFT;
    localparam int RW    = AW + 1 - FS;

    logic signed [CW-1:0] den_coef_reg [spiir_pkg::TAPS];
    logic signed [CW-1:0] num_coef_reg [spiir_pkg::TAPS];
    logic signed [SW-1:0] in_hist_reg  [ORDER];
    logic signed [SW-1:0] out_hist_reg [ORDER];

    logic signed [SW-1:0] sample_reg;
    logic [TAP_W-1:0]     tap_reg;
    logic                 phase_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_neg_reg;
    logic                 prod_valid_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 out_valid_reg;
    logic [SW-1:0]        out_data_reg;

    logic [spiir_pkg::COEF_IDX_W-1:0] coef_idx;
    logic signed [SW-1:0]  op_a;
    logic signed [CW-1:0]  op_b;
    logic signed [PW-1:0]  prod_next;
    logic signed [AW-1:0]  prod_ext;
    logic signed [AW-1:0]  acc_next;
    logic signed [AW:0]    rnd;
    logic [RW-1:0]         rnd_shr;
    logic [SW-1:0]         y_sat;

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < spiir_pkg::TAPS; i++) begin
                den_coef_reg[i] <= '0;
                num_coef_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index < spiir_pkg::CFG_NUM_BASE) begin
                den_coef_reg[cfg_index[spiir_pkg::COEF_IDX_W-1:0]] <= cfg_data;
            end else begin
                num_coef_reg[cfg_index[spiir_pkg::COEF_IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    // operand select and multiply
    assign coef_idx  = spiir_pkg::COEF_IDX_W'(tap_reg);
    assign op_a      = phase_reg ? out_hist_reg[tap_reg] : in_hist_reg[tap_reg];
    assign op_b      = phase_reg ? den_coef_reg[coef_idx] : num_coef_reg[coef_idx];
    assign prod_next = op_a * op_b;

    assign prod_ext  = {{(AW - PW){prod_reg[PW-1]}}, prod_reg};
    assign acc_next  = prod_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);

    // round to nearest (ties up), floor shift, saturate
    assign rnd     = {acc_reg[AW-1], acc_reg} + (AW + 1)'(1 << (FS - 1));
    assign rnd_shr = rnd[AW:FS];

    always_comb begin
        if (&rnd_shr[RW-1:SW-1] || ~|rnd_shr[RW-1:SW-1]) begin
            y_sat = rnd_shr[SW-1:0];
        end else if (rnd_shr[RW-1]) begin
            y_sat = {1'b1, {(SW - 1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SW - 1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) sample_reg <= s_tdata;
        if (cmd.mac) begin
            prod_reg     <= prod_next;
            prod_neg_reg <= phase_reg;
        end
        if (cmd.finish) out_data_reg <= y_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg        <= '0;
            phase_reg      <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ORDER; i++) begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end else begin
            prod_valid_reg <= cmd.mac;
            if (cmd.clear) begin
                tap_reg   <= '0;
                phase_reg <= 1'b0;
                acc_reg   <= '0;
            end else begin
                if (prod_valid_reg) acc_reg <= acc_next;
                if (cmd.mac) begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg) tap_reg <= tap_reg + 1'b1;
                end
            end
            if (cmd.finish) begin
                for (int i = ORDER - 1; i > 0; i--) begin
                    in_hist_reg[i]  <= in_hist_reg[i-1];
                    out_hist_reg[i] <= out_hist_reg[i-1];
                end
                in_hist_reg[0]  <= sample_reg;
                out_hist_reg[0] <= y_sat;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.last_step = phase_reg && (tap_reg == LAST_TAP);
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

endmodule

[design/strictly_proper_iir_filter_top.sv]
// Strictly proper direct form I IIR filter (discrete plant model).
// Input channel s_*: one Q16.16 drive sample per request. Result channel m_*:
// one Q16.16 plant output per accepted sample, in order. The output uses only
// past inputs and outputs, so a sample first shows in the following result.
// Coefficients (Q4.20) are written through cfg_we/cfg_index/cfg_data while
// the filter is idle: index 0..3 den_coef_1..4, index 4..7 num_coef_1..4.
// Timing: a request is taken in the idle state, then one shared 32x24
// multiplier runs 2*ORDER products (one per cycle, each accumulated in the
// cycle after), a drain step accumulates the last product and a round step
// rounds, saturates and loads the output register. No new request is
// taken until the round step is done and the sequencer is back in idle,
// as the single multiply-accumulate unit serves one sample at a time.
// The output register holds its result until m_tready; the next request is
// taken meanwhile, and the round step waits if the old result is still there.
// Reset (aresetn low, synchronous) clears coefficients, both histories and
// all handshake state.
module strictly_proper_iir_filter_top #(
    parameter int ORDER = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [spiir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spiir_pkg::COEF_W-1:0]        cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spiir_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample_in
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spiir_pkg::SAMPLE_W-1:0]      m_tdata    // [31:0] sample_out
);

    spiir_pkg::spiir_cmd_t cmd;
    spiir_pkg::spiir_sts_t sts;

    // sequencer: idle, multiply-accumulate, drain, round
    spiir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // coefficients, histories, shared multiplier, accumulator, output register
    spiir_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // after taking a request, hold off the next one while it is worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after accept");

    // a result never appears in the cycle right after its request
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result raised too early");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    // a result only appears right after a round step
    a_finish_after_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("result raised without a round step");

endmodule
